// ----- rtl/rcip_pkg.sv -----
`timescale 1ns / 1ps
package rcip_pkg;

  localparam int unsigned ROTOR_SIZE = 256;
  localparam int unsigned IDX_W      = $clog2(ROTOR_SIZE);
  localparam int unsigned KEY_LEN    = 13;
  localparam logic [31:0] SEED_INIT  = 32'd123;
  localparam logic [16:0] SEED_MOD   = 17'd65521;
  localparam logic [3:0]  PW_MAX     = 4'd8;
  localparam logic [0:0]  REG_PASSWORD     = 1'b0;
  localparam logic [0:0]  REG_PASSWORD_LEN = 1'b1;

  typedef struct packed {
    logic [7:0] data;
    logic       build;
    logic       last;
  } item_t;

  typedef struct packed {
    logic       start;
    logic [7:0] dividend;
    logic [8:0] divisor;
  } div_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FILL,
    ST_SEED,
    ST_MIX,
    ST_FOLD,
    ST_REDUCE,
    ST_RDIV,
    ST_RDIV_WAIT,
    ST_RD_K,
    ST_RD_P,
    ST_SW_K,
    ST_SW_P,
    ST_RF_A,
    ST_RF_D,
    ST_FDIV_WAIT,
    ST_PR_A,
    ST_PR_D,
    ST_PW_K,
    ST_PW_P,
    ST_NEXT,
    ST_INV_A,
    ST_INV_D,
    ST_E1,
    ST_E2,
    ST_E3,
    ST_E4
  } state_t;

endpackage

// ----- rtl/rcip_if.sv -----
`timescale 1ns / 1ps
interface rcip_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_in;
  logic       restart;
  logic       last_in;
  modport source (output valid, data_in, restart, last_in, input ready);
  modport sink (input valid, data_in, restart, last_in, output ready);
endinterface

interface rcip_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;
  logic       last_out;
  modport source (output valid, data_out, last_out, input ready);
  modport sink (input valid, data_out, last_out, output ready);
endinterface

// ----- rtl/rcip_front.sv -----
`timescale 1ns / 1ps
module rcip_front (
  input  logic              clk,
  input  logic              rst,
  rcip_in_if.sink           in,
  input  logic              full,
  output logic              push,
  output rcip_pkg::item_t   push_item
);

  logic built;

  assign in.ready = !full;
  assign push     = in.valid && !full;

  always_comb begin
    push_item.data  = in.data_in;
    push_item.build = in.restart || !built;
    push_item.last  = in.last_in;
  end

  // first transfer after reset always rebuilds the tables
  always_ff @(posedge clk) begin
    if (rst) begin
      built <= 1'b0;
    end else if (push) begin
      built <= 1'b1;
    end
  end

endmodule

// ----- rtl/rcip_queue.sv -----
`timescale 1ns / 1ps
module rcip_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rcip_pkg::item_t   push_item,
  input  logic              pop,
  output rcip_pkg::item_t   head,
  output logic              full,
  output logic              empty
);

  rcip_pkg::item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/rcip_div.sv -----
`timescale 1ns / 1ps
module rcip_div (
  input  logic                clk,
  input  logic                rst,
  input  rcip_pkg::div_req_t  req,
  output logic                done,
  output logic [7:0]          rem_out
);

  logic       busy;
  logic [2:0] cnt;
  logic [7:0] dvd;
  logic [8:0] dsr;
  logic [8:0] rem;
  logic [9:0] trial;

  assign trial   = {rem, dvd[7]};
  assign rem_out = rem[7:0];

  // restoring remainder, one dividend bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 3'd7) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt <= 3'd0;
      dvd <= req.dividend;
      dsr <= req.divisor;
      rem <= 9'd0;
    end else if (busy) begin
      cnt <= cnt + 3'd1;
      dvd <= {dvd[6:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        rem <= 9'(trial - {1'b0, dsr});
      end else begin
        rem <= trial[8:0];
      end
    end
  end

endmodule

// ----- rtl/rcip_back.sv -----
`timescale 1ns / 1ps
module rcip_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [63:0]       cfg_data,
  input  logic              empty,
  input  rcip_pkg::item_t   head,
  output logic              pop,
  rcip_out_if.source        out
);

  rcip_pkg::state_t   state;
  rcip_pkg::state_t   state_next;
  rcip_pkg::div_req_t div_req;

  logic [63:0] password;
  logic [3:0]  password_length;
  logic [3:0]  len_eff;
  logic [31:0] key [rcip_pkg::KEY_LEN];

  logic [7:0]  i;
  logic [7:0]  k;
  logic [3:0]  kidx;
  logic [31:0] s;
  logic        neg;
  logic [19:0] f1;
  logic [31:0] mag;
  logic [16:0] f2;
  logic [15:0] rm;
  logic [15:0] r16;
  logic [7:0]  pos;
  logic [7:0]  probes;
  logic [7:0]  rk;
  logic [7:0]  b;
  logic        lastq;
  logic [7:0]  n1;
  logic [7:0]  n2;
  logic        div_done;
  logic [7:0]  div_rem;
  logic        out_free;
  logic        pair;
  logic        probe_more;

  logic [7:0] rot_mem [rcip_pkg::ROTOR_SIZE];
  logic [7:0] ref_mem [rcip_pkg::ROTOR_SIZE];
  logic [7:0] inv_mem [rcip_pkg::ROTOR_SIZE];
  logic [7:0] rot_ra, ref_ra, inv_ra;
  logic [7:0] rot_q, ref_q, inv_q;
  logic       rot_we, ref_we, inv_we;
  logic [7:0] rot_wa, ref_wa, inv_wa;
  logic [7:0] rot_wd, ref_wd, inv_wd;

  always_ff @(posedge clk) begin
    if (rst) begin
      password        <= 64'd0;
      password_length <= 4'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rcip_pkg::REG_PASSWORD:     password        <= cfg_data;
        rcip_pkg::REG_PASSWORD_LEN: password_length <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // sign-extended key bytes, bytes 8 and 9 repeat 0 and 1
  assign len_eff = (password_length > rcip_pkg::PW_MAX) ? rcip_pkg::PW_MAX : password_length;
  always_comb begin
    for (int n = 0; n < 8; n++) begin
      if (4'(n) < len_eff) begin
        key[n] = {{24{password[8*n+7]}}, password[8*n +: 8]};
      end else begin
        key[n] = 32'd0;
      end
    end
    key[8]  = key[0];
    key[9]  = key[1];
    key[10] = 32'd0;
    key[11] = 32'd0;
    key[12] = 32'd0;
  end

  assign k          = ~i;
  assign out_free   = !out.valid || out.ready;
  assign pop        = (state == rcip_pkg::ST_IDLE) && !empty && out_free;
  assign pair       = (ref_q == 8'd0) && (k != 8'd0);
  assign probe_more = (ref_q != 8'd0) && (probes < k);

  // remainder by 65521 through folding, since 2^16 = 15 mod 65521
  assign mag = s[31] ? 32'(0 - s) : s;
  assign f2  = 17'({13'd0, f1[19:16]} * 17'd15) + {1'b0, f1[15:0]};
  assign rm  = (f2 >= rcip_pkg::SEED_MOD) ? 16'(f2 - rcip_pkg::SEED_MOD) : f2[15:0];

  always_ff @(posedge clk) begin
    rot_q <= rot_mem[rot_ra];
    ref_q <= ref_mem[ref_ra];
    inv_q <= inv_mem[inv_ra];
    if (rot_we) begin
      rot_mem[rot_wa] <= rot_wd;
    end
    if (ref_we) begin
      ref_mem[ref_wa] <= ref_wd;
    end
    if (inv_we) begin
      inv_mem[inv_wa] <= inv_wd;
    end
  end

  rcip_div u_div (
    .clk     (clk),
    .rst     (rst),
    .req     (div_req),
    .done    (div_done),
    .rem_out (div_rem)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      rcip_pkg::ST_IDLE: begin
        if (pop) begin
          state_next = head.build ? rcip_pkg::ST_FILL : rcip_pkg::ST_E1;
        end
      end
      rcip_pkg::ST_FILL:   if (i == 8'd255) state_next = rcip_pkg::ST_SEED;
      rcip_pkg::ST_SEED:   if (kidx == 4'(rcip_pkg::KEY_LEN - 1)) state_next = rcip_pkg::ST_MIX;
      rcip_pkg::ST_MIX:    state_next = rcip_pkg::ST_FOLD;
      rcip_pkg::ST_FOLD:   state_next = rcip_pkg::ST_REDUCE;
      rcip_pkg::ST_REDUCE: state_next = rcip_pkg::ST_RDIV;
      rcip_pkg::ST_RDIV:   state_next = rcip_pkg::ST_RDIV_WAIT;
      rcip_pkg::ST_RDIV_WAIT: if (div_done) state_next = rcip_pkg::ST_RD_K;
      rcip_pkg::ST_RD_K:   state_next = rcip_pkg::ST_RD_P;
      rcip_pkg::ST_RD_P:   state_next = rcip_pkg::ST_SW_K;
      rcip_pkg::ST_SW_K:   state_next = rcip_pkg::ST_SW_P;
      rcip_pkg::ST_SW_P:   state_next = rcip_pkg::ST_RF_A;
      rcip_pkg::ST_RF_A:   state_next = rcip_pkg::ST_RF_D;
      rcip_pkg::ST_RF_D:   state_next = pair ? rcip_pkg::ST_FDIV_WAIT : rcip_pkg::ST_NEXT;
      rcip_pkg::ST_FDIV_WAIT: if (div_done) state_next = rcip_pkg::ST_PR_A;
      rcip_pkg::ST_PR_A:   state_next = rcip_pkg::ST_PR_D;
      rcip_pkg::ST_PR_D:   state_next = probe_more ? rcip_pkg::ST_PR_A : rcip_pkg::ST_PW_K;
      rcip_pkg::ST_PW_K:   state_next = rcip_pkg::ST_PW_P;
      rcip_pkg::ST_PW_P:   state_next = rcip_pkg::ST_NEXT;
      rcip_pkg::ST_NEXT:   state_next = (i == 8'd255) ? rcip_pkg::ST_INV_A : rcip_pkg::ST_MIX;
      rcip_pkg::ST_INV_A:  state_next = rcip_pkg::ST_INV_D;
      rcip_pkg::ST_INV_D:  state_next = (i == 8'd255) ? rcip_pkg::ST_E1 : rcip_pkg::ST_INV_A;
      rcip_pkg::ST_E1:     state_next = rcip_pkg::ST_E2;
      rcip_pkg::ST_E2:     state_next = rcip_pkg::ST_E3;
      rcip_pkg::ST_E3:     state_next = rcip_pkg::ST_E4;
      rcip_pkg::ST_E4:     state_next = rcip_pkg::ST_IDLE;
      default:             state_next = rcip_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rot_ra = 8'd0;
    ref_ra = 8'd0;
    inv_ra = 8'd0;
    rot_we = 1'b0;
    ref_we = 1'b0;
    inv_we = 1'b0;
    rot_wa = 8'd0;
    ref_wa = 8'd0;
    inv_wa = 8'd0;
    rot_wd = 8'd0;
    ref_wd = 8'd0;
    inv_wd = 8'd0;
    div_req.start    = 1'b0;
    div_req.dividend = r16[7:0];
    div_req.divisor  = 9'({1'b0, k} + 9'd1);
    unique case (state)
      rcip_pkg::ST_FILL: begin
        rot_we = 1'b1;
        rot_wa = i;
        rot_wd = i;
        ref_we = 1'b1;
        ref_wa = i;
        ref_wd = 8'd0;
      end
      rcip_pkg::ST_RDIV: div_req.start = 1'b1;
      rcip_pkg::ST_RD_K: rot_ra = k;
      rcip_pkg::ST_RD_P: rot_ra = pos;
      rcip_pkg::ST_SW_K: begin
        rot_we = 1'b1;
        rot_wa = k;
        rot_wd = rot_q;
      end
      rcip_pkg::ST_SW_P: begin
        rot_we = 1'b1;
        rot_wa = pos;
        rot_wd = rk;
      end
      rcip_pkg::ST_RF_A: ref_ra = k;
      rcip_pkg::ST_RF_D: begin
        div_req.start    = pair;
        div_req.dividend = r16[15:8];
        div_req.divisor  = {1'b0, k};
      end
      rcip_pkg::ST_PR_A: ref_ra = pos;
      rcip_pkg::ST_PW_K: begin
        ref_we = 1'b1;
        ref_wa = k;
        ref_wd = pos;
      end
      rcip_pkg::ST_PW_P: begin
        ref_we = 1'b1;
        ref_wa = pos;
        ref_wd = k;
      end
      rcip_pkg::ST_INV_A: rot_ra = i;
      rcip_pkg::ST_INV_D: begin
        inv_we = 1'b1;
        inv_wa = rot_q;
        inv_wd = i;
      end
      rcip_pkg::ST_E1: rot_ra = 8'(b + n1);
      rcip_pkg::ST_E2: ref_ra = 8'(rot_q + n2);
      rcip_pkg::ST_E3: inv_ra = 8'(ref_q - n2);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rcip_pkg::ST_IDLE;
      n1        <= 8'd0;
      n2        <= 8'd0;
      out.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out.valid && out.ready) begin
        out.valid <= 1'b0;
      end
      if (pop && head.build) begin
        n1 <= 8'd0;
        n2 <= 8'd0;
      end
      if (state == rcip_pkg::ST_E4) begin
        out.valid <= 1'b1;
        n1        <= n1 + 8'd1;
        if (n1 == 8'd255) begin
          n2 <= n2 + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      rcip_pkg::ST_IDLE: begin
        if (pop) begin
          b     <= head.data;
          lastq <= head.last;
          i     <= 8'd0;
          kidx  <= 4'd0;
          s     <= rcip_pkg::SEED_INIT;
        end
      end
      rcip_pkg::ST_FILL: i <= i + 8'd1;
      rcip_pkg::ST_SEED: begin
        s <= 32'(s * key[kidx]) + {28'd0, kidx};
        kidx <= (kidx == 4'(rcip_pkg::KEY_LEN - 1)) ? 4'd0 : kidx + 4'd1;
      end
      rcip_pkg::ST_MIX: s <= {s[29:0], 2'b00} + s + key[kidx];
      rcip_pkg::ST_FOLD: begin
        neg <= s[31];
        f1  <= 20'({4'd0, mag[31:16]} * 20'd15) + {4'd0, mag[15:0]};
      end
      rcip_pkg::ST_REDUCE: r16 <= neg ? 16'(0 - rm) : rm;
      rcip_pkg::ST_RDIV_WAIT: if (div_done) pos <= div_rem;
      rcip_pkg::ST_RD_P: rk <= rot_q;
      rcip_pkg::ST_FDIV_WAIT: begin
        if (div_done) begin
          pos    <= div_rem;
          probes <= 8'd1;
        end
      end
      rcip_pkg::ST_PR_D: begin
        if (probe_more) begin
          pos    <= (8'(pos + 8'd1) == k) ? 8'd0 : pos + 8'd1;
          probes <= probes + 8'd1;
        end
      end
      rcip_pkg::ST_NEXT: begin
        i    <= i + 8'd1;
        kidx <= (kidx == 4'(rcip_pkg::KEY_LEN - 1)) ? 4'd0 : kidx + 4'd1;
      end
      rcip_pkg::ST_INV_D: i <= i + 8'd1;
      rcip_pkg::ST_E4: begin
        out.data_out <= 8'(inv_q - n1);
        out.last_out <= lastq;
      end
      default: ;
    endcase
  end

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == rcip_pkg::ST_RDIV_WAIT || state == rcip_pkg::ST_FDIV_WAIT))
    else $error("divider result with no one waiting");

  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    (state == rcip_pkg::ST_PR_A) |-> (probes != 8'd0 && probes <= k))
    else $error("reflector search beyond its bound");

  a_build_starts: assert property (@(posedge clk) disable iff (rst)
    (pop && head.build) |=> (state == rcip_pkg::ST_FILL && n1 == 8'd0 && n2 == 8'd0))
    else $error("rebuild did not start with cleared counters");

  a_result_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == rcip_pkg::ST_E4) |-> !out.valid)
    else $error("result would overwrite a pending transfer");

endmodule

// ----- rtl/three_rotor_byte_cipher_top.sv -----
`timescale 1ns / 1ps
// an item without rebuild is popped from the queue and then passes the four dependent table-read steps E1 to E4
// before its result is registered; a new item is popped only once the last one is done and the output slot is free
// rebuild items first rebuild the tables, which takes longer for every extra reflector search probe
// rst is synchronous: counters and handshakes clear, tables rebuild on the first item
module three_rotor_byte_cipher_top (
  input  logic         clk,
  input  logic         rst,
  rcip_in_if.sink      in,
  rcip_out_if.source   out,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  rcip_pkg::item_t push_item;
  rcip_pkg::item_t head;
  logic push, pop, full, empty;

  rcip_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in        (in),
    .full      (full),
    .push      (push),
    .push_item (push_item)
  );

  rcip_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  rcip_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .out       (out)
  );

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

  localparam int STALL_LIMIT = 200000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 210;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cipher_out_t;

  typedef struct {
    bit          set_key;
    logic [63:0] pw;
    logic [3:0]  pw_len;
    logic [7:0]  data;
    logic        restart;
    logic        last;
  } script_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [63:0] cfg_data;

  rcip_in_if  in_ch ();
  rcip_out_if out_ch ();

  three_rotor_byte_cipher_top uut (
    .clk       (clk),
    .rst       (rst),
    .in        (in_ch),
    .out       (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor copy of the machine
  logic [63:0] key_bytes;
  logic [3:0]  key_len;
  logic [7:0]  rotor [256];
  logic [7:0]  rotor_inv [256];
  logic [7:0]  reflector [256];
  logic [7:0]  fast_n;
  logic [7:0]  slow_n;
  bit          tables_built;

  cipher_out_t cipher_q[$];
  int          errors;
  bit          calm;
  int          quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [15:0] seed_mod16(logic [31:0] s);
    logic [31:0] mag;
    logic [31:0] r;
    if (s[31]) begin
      mag = 32'd0 - s;
      r = mag % 32'd65521;
      return 16'(32'h10000 - r);
    end
    return 16'(s % 32'd65521);
  endfunction

  function automatic void rebuild_tables();
    logic [31:0] key [13];
    logic [31:0] s;
    logic [31:0] r;
    logic [31:0] k;
    logic [31:0] pos;
    logic [31:0] probes;
    logic [7:0]  b;
    logic [7:0]  t;
    int          len;
    len = (key_len > 4'd8) ? 8 : int'(key_len);
    for (int i = 0; i < 13; i++) key[i] = 32'd0;
    for (int i = 0; i < len; i++) begin
      b = key_bytes[8*i +: 8];
      key[i] = {{24{b[7]}}, b};
    end
    key[8] = key[0];
    key[9] = key[1];
    s = 32'd123;
    for (int i = 0; i < 13; i++) s = s * key[i] + 32'(i);
    for (int i = 0; i < 256; i++) begin
      reflector[i] = 8'd0;
      rotor[i] = 8'(i);
    end
    for (int i = 0; i < 256; i++) begin
      k = 32'd255 - 32'(i);
      s = 32'd5 * s + key[i % 13];
      r = {16'd0, seed_mod16(s)};
      pos = (r & 32'hFF) % (k + 32'd1);
      t = rotor[k];
      rotor[k] = rotor[pos];
      rotor[pos] = t;
      if (reflector[k] != 8'd0 || k == 32'd0) continue;
      pos = ((r >> 8) & 32'hFF) % k;
      for (probes = 1; reflector[pos] != 8'd0 && probes < k; probes++)
        pos = (pos + 32'd1) % k;
      reflector[k] = 8'(pos);
      reflector[pos] = 8'(k);
    end
    for (int i = 0; i < 256; i++) rotor_inv[rotor[i]] = 8'(i);
    tables_built = 1'b1;
  endfunction

  function automatic void encipher(logic [7:0] d, logic restart, logic last);
    cipher_out_t o;
    logic [7:0]  v;
    if (restart || !tables_built) begin
      rebuild_tables();
      fast_n = 8'd0;
      slow_n = 8'd0;
    end
    v = rotor[8'(d + fast_n)];
    v = reflector[8'(v + slow_n)];
    v = rotor_inv[8'(v - slow_n)];
    o.data = 8'(v - fast_n);
    o.last = last;
    fast_n = fast_n + 8'd1;
    if (fast_n == 8'd0) slow_n = slow_n + 8'd1;
    cipher_q.push_back(o);
  endfunction

  task automatic send_byte(logic [7:0] d, logic restart, logic last);
    in_ch.valid   <= 1'b1;
    in_ch.data_in <= d;
    in_ch.restart <= restart;
    in_ch.last_in <= last;
    do @(posedge clk); while (!in_ch.ready);
    encipher(d, restart, last);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (cipher_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == rcip_pkg::REG_PASSWORD) key_bytes = val;
    else key_len = val[3:0];
  endtask

  task automatic set_key(logic [63:0] pw, logic [3:0] len);
    drain();
    write_reg(rcip_pkg::REG_PASSWORD, pw);
    write_reg(rcip_pkg::REG_PASSWORD_LEN, {60'd0, len});
  endtask

  // result checker
  always @(posedge clk) begin
    cipher_out_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (cipher_q.size() == 0) begin
        $error("unexpected transfer data_out=%0h last_out=%0b",
               out_ch.data_out, out_ch.last_out);
        errors++;
      end else begin
        want = cipher_q.pop_front();
        if (out_ch.data_out !== want.data) begin
          $error("data_out expected %0h actual %0h", want.data, out_ch.data_out);
          errors++;
        end
        if (out_ch.last_out !== want.last) begin
          $error("last_out expected %0b actual %0b", want.last, out_ch.last_out);
          errors++;
        end
      end
    end
  end

  // receiver stalls
  initial begin
    out_ch.ready <= 1'b1;
    forever begin
      repeat ($urandom_range(1, 12)) @(posedge clk);
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  script_row_t script [12];

  initial begin
    logic [63:0] pw;
    logic [3:0]  len;
    errors = 0;
    calm = 1'b0;
    quiet_cycles = 0;
    tables_built = 1'b0;
    fast_n = 8'd0;
    slow_n = 8'd0;
    key_bytes = 64'd0;
    key_len = 4'd0;
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= rcip_pkg::REG_PASSWORD;
    cfg_data      <= 64'd0;
    in_ch.valid   <= 1'b0;
    in_ch.data_in <= 8'd0;
    in_ch.restart <= 1'b0;
    in_ch.last_in <= 1'b0;

    // first byte builds the tables even without restart
    script[0]  = '{0, 64'd0, 4'd0, 8'h00, 1'b0, 1'b0};
    script[1]  = '{0, 64'd0, 4'd0, 8'hFF, 1'b0, 1'b1};
    script[2]  = '{0, 64'd0, 4'd0, 8'h80, 1'b0, 1'b0};
    // new key without restart keeps the old tables
    script[3]  = '{1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 8'h00, 1'b0, 1'b0};
    script[4]  = '{0, 64'd0, 4'd0, 8'h00, 1'b1, 1'b0};
    script[5]  = '{0, 64'd0, 4'd0, 8'hFF, 1'b0, 1'b1};
    // length above eight clamps
    script[6]  = '{1, 64'h0123_4567_89AB_CDEF, 4'd15, 8'h55, 1'b1, 1'b0};
    script[7]  = '{0, 64'd0, 4'd0, 8'hAA, 1'b0, 1'b1};
    script[8]  = '{1, 64'h8080_8080_8080_8080, 4'd1, 8'h01, 1'b1, 1'b0};
    script[9]  = '{1, 64'h7F7F_7F7F_7F7F_7F7F, 4'd2, 8'hFE, 1'b1, 1'b1};
    // zero length ignores the password
    script[10] = '{1, 64'hDEAD_BEEF_CAFE_F00D, 4'd0, 8'h7F, 1'b1, 1'b0};
    script[11] = '{0, 64'd0, 4'd0, 8'h01, 1'b0, 1'b0};

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].set_key) set_key(script[i].pw, script[i].pw_len);
      send_byte(script[i].data, script[i].restart, script[i].last);
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin pw = 64'hFFFF_FFFF_FFFF_FFFF; len = 4'd8; end
        1: begin pw = 64'd0; len = 4'd0; end
        2: begin pw = {$urandom, $urandom}; len = 4'd15; end
        default: begin pw = {$urandom, $urandom}; len = 4'($urandom_range(0, 15)); end
      endcase
      if (p == PHASES - 1) begin
        drain();
        calm = 1'b1;
      end
      set_key(pw, len);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_byte(8'($urandom_range(0, 255)),
                  (n == 0) || ($urandom_range(0, 299) == 0),
                  $urandom_range(0, 15) == 0);
    end

    in_ch.valid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
